### design/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared widths, register indexes and reset values for the battery
// low-voltage monitor.
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int ADC_W      = 12;
    localparam int MV_W       = 16;
    localparam int THRESH_W   = 16;
    localparam int PERSIST_W  = 16;
    localparam int SCALE_W    = 20;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam int WINDOW_DEFAULT = 10;

    // input beat: adc_sample padded to whole bytes
    localparam int S_TDATA_W = 16;
    // output beat: voltage_mv, average_counts, low_voltage padded to bytes
    localparam int M_TDATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERSIST_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_Q16     = 2'd2;

    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd3400;
    localparam logic [PERSIST_W-1:0] PERSIST_RESET = 16'd1000;
    localparam logic [SCALE_W-1:0]   SCALE_RESET   = 20'd52796;

    localparam logic [MV_W-1:0]    MV_MAX    = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

### design/bvm_ram.sv
// ----------------------------------------------------------------------------
// bvm_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module bvm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/battery_low_voltage_monitor.sv
// ----------------------------------------------------------------------------
// battery_low_voltage_monitor
// Moving-average undervoltage detector for a battery divider ADC.
// ----------------------------------------------------------------------------
// Takes one 12-bit ADC sample per beat and returns one beat per sample with
// the window average (floored), the battery voltage in mV and a low flag.
// Throughput is one sample per clock unless output stalls. The window lives
// in a WINDOW-deep circular RAM: each sample is written over the oldest
// entry while that entry is read out, and a running sum is updated with
// (new - oldest). The first sample after reset stands for the whole window;
// RAM entries not yet written since then read as that first sample, so no
// clearing pass is needed. Division by WINDOW is a reciprocal multiply with
// one correction step. Voltage is avg * scale_q16 * 2 / 65536, saturated to
// 65535. The low flag is set when the count of consecutive readings below
// low_threshold_mv (saturating at 65535) exceeds persist_limit. The output
// register is elastic: samples keep entering while a result waits, until
// all six stages hold an item. The user must write config registers through
// cfg_we / cfg_addr / cfg_wdata only while the block is idle; the block does
// not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module battery_low_voltage_monitor #(
    parameter int WINDOW = bvm_pkg::WINDOW_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_we,
    input  logic [bvm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bvm_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [11:0] adc_sample
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] voltage_mv, [27:16] average_counts, [28] low_voltage
    output logic [bvm_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int ADC_W   = bvm_pkg::ADC_W;
    localparam int AW      = $clog2(WINDOW);
    localparam int SUM_MAX = WINDOW * ((1 << ADC_W) - 1);
    localparam int SUMW    = $clog2(SUM_MAX + 1);
    // floor(2^SUMW / WINDOW); estimate is never high and at most one low
    localparam logic [SUMW-1:0] RECIP = SUMW'((64'd1 << SUMW) / WINDOW);
    localparam logic [AW-1:0]   PTR_LAST = AW'(WINDOW - 1);
    localparam logic [SUMW-1:0] WIN_S    = SUMW'(WINDOW);
    localparam int PRODW = bvm_pkg::ADC_W + bvm_pkg::SCALE_W;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [bvm_pkg::THRESH_W-1:0]  thresh_reg;
    logic [bvm_pkg::PERSIST_W-1:0] persist_reg;
    logic [bvm_pkg::SCALE_W-1:0]   scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg  <= bvm_pkg::THRESH_RESET;
            persist_reg <= bvm_pkg::PERSIST_RESET;
            scale_reg   <= bvm_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bvm_pkg::REG_LOW_THRESHOLD:
                    thresh_reg <= cfg_wdata[bvm_pkg::THRESH_W-1:0];
                bvm_pkg::REG_PERSIST_LIMIT:
                    persist_reg <= cfg_wdata[bvm_pkg::PERSIST_W-1:0];
                bvm_pkg::REG_SCALE_Q16:
                    scale_reg <= cfg_wdata[bvm_pkg::SCALE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage moves when the next one is free or moving
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;
    logic go1, go2, go3, go4, go5;
    logic accept;

    assign rdyo = !vo_reg || m_axis_tready;
    assign rdy5 = !v5_reg || rdyo;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign go1 = v1_reg && rdy2;
    assign go2 = v2_reg && rdy3;
    assign go3 = v3_reg && rdy4;
    assign go4 = v4_reg && rdy5;
    assign go5 = v5_reg && rdyo;

    assign s_axis_tready = rdy1;
    assign accept        = s_axis_tvalid && rdy1;

    // ------------------------------------------------------------------
    // Accept: write new sample over the oldest entry, read the oldest out
    // ------------------------------------------------------------------
    logic [ADC_W-1:0] sample;
    logic [AW-1:0]    ptr_reg;
    logic             first_reg;
    logic             wrapped_reg;
    logic [ADC_W-1:0] fill_reg;      // first sample, stands for unwritten entries
    logic [ADC_W-1:0] ram_rdata;

    assign sample = s_axis_tdata[ADC_W-1:0];

    bvm_ram #(
        .WIDTH (ADC_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (accept),
        .waddr (ptr_reg),
        .wdata (sample),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            first_reg   <= 1'b1;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            first_reg <= 1'b0;
            if (ptr_reg == PTR_LAST)
            begin
                ptr_reg     <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                ptr_reg <= ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && first_reg)
        begin
            fill_reg <= sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: running sum update
    // ------------------------------------------------------------------
    logic [ADC_W-1:0] s1_sample_reg;
    logic             s1_first_reg;
    logic             s1_wrapped_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [SUMW-1:0]  sum_next;
    logic [ADC_W-1:0] oldest;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= sample;
            s1_first_reg   <= first_reg;
            s1_wrapped_reg <= wrapped_reg;
        end
    end

    always_comb
    begin
        oldest = s1_wrapped_reg ? ram_rdata : fill_reg;
        if (s1_first_reg)
        begin
            sum_next = SUMW'(s1_sample_reg * WIN_S);
        end
        else
        begin
            sum_next = sum_reg - SUMW'(oldest) + SUMW'(s1_sample_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (go1)
        begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: reciprocal multiply; stage 3: correction
    // ------------------------------------------------------------------
    logic [SUMW-1:0]   s2_sum_reg;
    logic [SUMW-1:0]   s3_sum_reg;
    logic [2*SUMW-1:0] s3_prod_reg;
    logic [SUMW-1:0]   quot;
    logic [SUMW-1:0]   rem;
    logic [ADC_W-1:0]  avg;

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            s2_sum_reg <= sum_next;
        end
        if (go2)
        begin
            s3_sum_reg  <= s2_sum_reg;
            s3_prod_reg <= s2_sum_reg * RECIP;
        end
    end

    always_comb
    begin
        quot = s3_prod_reg[2*SUMW-1:SUMW];
        rem  = s3_sum_reg - SUMW'(quot * WIN_S);
        if (rem >= WIN_S)
        begin
            avg = ADC_W'(quot + SUMW'(1));
        end
        else
        begin
            avg = ADC_W'(quot);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: millivolt product; stage 5: saturate, compare, count
    // ------------------------------------------------------------------
    logic [ADC_W-1:0]            s4_avg_reg;
    logic [ADC_W-1:0]            s5_avg_reg;
    logic [PRODW-1:0]            s5_prod_reg;
    logic [bvm_pkg::MV_W-1:0]    mv;
    logic [bvm_pkg::COUNT_W-1:0] count_reg;
    logic [bvm_pkg::COUNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (go3)
        begin
            s4_avg_reg <= avg;
        end
        if (go4)
        begin
            s5_avg_reg  <= s4_avg_reg;
            s5_prod_reg <= s4_avg_reg * scale_reg;
        end
    end

    // x2 then >>16 is >>15; anything above bit 15 of the result saturates
    always_comb
    begin
        if (s5_prod_reg[PRODW-1:bvm_pkg::MV_W + 15] != '0)
        begin
            mv = bvm_pkg::MV_MAX;
        end
        else
        begin
            mv = s5_prod_reg[bvm_pkg::MV_W + 14:15];
        end

        if (mv < thresh_reg)
        begin
            if (count_reg != bvm_pkg::COUNT_MAX)
            begin
                count_next = count_reg + bvm_pkg::COUNT_W'(1);
            end
            else
            begin
                count_next = count_reg;
            end
        end
        else
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (go5)
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [bvm_pkg::MV_W-1:0] out_mv_reg;
    logic [ADC_W-1:0]         out_avg_reg;
    logic                     out_low_reg;

    always_ff @(posedge clk)
    begin
        if (go5)
        begin
            out_mv_reg  <= mv;
            out_avg_reg <= s5_avg_reg;
            out_low_reg <= (count_next > persist_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdyo) vo_reg <= v5_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {3'b000, out_low_reg, out_avg_reg, out_mv_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the running sum never leaves the range of a full window
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUMW'(SUM_MAX))
        else $error("window sum out of range");

    // the reciprocal estimate is off by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (rem < (WIN_S << 1)))
        else $error("divide correction insufficient");

    // a flagged result implies a nonzero low-run count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_low_reg) |-> (count_reg != '0))
        else $error("low flag without low run");

    // ring wraps only after the first sample
    assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |-> !first_reg)
        else $error("window wrapped before first sample");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery low-voltage monitor.
// ----------------------------------------------------------------------------
// Streams ADC beats into the block and checks every result beat against a
// predictor kept in the bench. The predictor tracks the sample window, the
// mean, the mV conversion and the consecutive-low counter. Both stream sides
// idle at random. Register writes happen only with the pipeline drained.
// Tests run in turn:
//   - first-sample window fill and field extremes at reset settings
//   - register writes: unknown index, wide values, scale/threshold extremes
//   - random low/high runs under several register settings
//   - long low run against a large, the largest and a small persist limit
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ADC_W      = bvm_pkg::ADC_W;
    localparam int MV_W       = bvm_pkg::MV_W;
    localparam int THRESH_W   = bvm_pkg::THRESH_W;
    localparam int PERSIST_W  = bvm_pkg::PERSIST_W;
    localparam int SCALE_W    = bvm_pkg::SCALE_W;
    localparam int COUNT_W    = bvm_pkg::COUNT_W;
    localparam int CFG_ADDR_W = bvm_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = bvm_pkg::CFG_DATA_W;
    localparam int S_TDATA_W  = bvm_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = bvm_pkg::M_TDATA_W;

    localparam int WINDOW       = bvm_pkg::WINDOW_DEFAULT;
    localparam int IDLE_PCT     = 22;     // idle / stall chance per cycle, percent
    localparam int STALL_LIMIT  = 5000;   // cycles with no beat on either side
    localparam int TAIL_CYCLES  = 12;     // longer than the pipeline latency
    localparam int PHASE_ITEMS  = 220;
    localparam int LOW_ITEMS    = 60;     // length of the all-low run

    // index with no register behind it; writes must be dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // result beat layout, lowest field last: {low_voltage, average_counts, voltage_mv}
    typedef struct packed {
        logic              low_voltage;
        logic [ADC_W-1:0]  average_counts;
        logic [MV_W-1:0]   voltage_mv;
    } reading_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;   // [11:0] adc_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [15:0] voltage_mv, [27:16] average_counts, [28] low_voltage
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // predictor state and its copy of the registers
    logic [ADC_W-1:0]       win [WINDOW];
    bit                     fill_pending = 1'b1;
    logic [COUNT_W-1:0]     low_run      = '0;
    logic [THRESH_W-1:0]    thresh_mv    = bvm_pkg::THRESH_RESET;
    logic [PERSIST_W-1:0]   persist      = bvm_pkg::PERSIST_RESET;
    logic [SCALE_W-1:0]     scale        = bvm_pkg::SCALE_RESET;

    reading_t               readings_due[$];
    int                     err_cnt      = 0;
    int                     quiet_cycles = 0;
    bit                     no_gaps      = 1'b0;   // both sides run flat out while set

    battery_low_voltage_monitor #(
        .WINDOW(WINDOW)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // avg * scale * 2 is exact in 34 bits; floor by >> 16, then clip
    function automatic logic [MV_W-1:0] counts_to_mv(input logic [ADC_W-1:0] avg,
                                                     input logic [SCALE_W-1:0] k);
        logic [33:0] prod;
        prod = 34'(avg) * 34'(k) * 34'd2;
        prod = prod >> 16;
        return (prod > 34'(bvm_pkg::MV_MAX)) ? bvm_pkg::MV_MAX : prod[MV_W-1:0];
    endfunction

    function automatic reading_t predict_reading(input logic [ADC_W-1:0] adc);
        reading_t r;
        int       sum;
        // first reading after reset stands for the whole window
        if (fill_pending)
        begin
            foreach (win[i]) win[i] = adc;
            fill_pending = 1'b0;
        end
        for (int i = WINDOW - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = adc;
        sum = 0;
        foreach (win[i]) sum += win[i];
        r.average_counts = ADC_W'(sum / WINDOW);
        r.voltage_mv     = counts_to_mv(r.average_counts, scale);
        if (r.voltage_mv < thresh_mv)
        begin
            if (low_run != bvm_pkg::COUNT_MAX) low_run++;
        end
        else
        begin
            low_run = '0;
        end
        r.low_voltage = (low_run > persist);
        return r;
    endfunction

    // first average whose voltage is not below the threshold (4096: none)
    function automatic int low_boundary();
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 1 << ADC_W;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (counts_to_mv(ADC_W'(mid), scale) < thresh_mv) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    task automatic push_sample(input logic [S_TDATA_W-1:0] word);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'($urandom);   // junk while idle
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge clk); while (!s_axis_tready);
        readings_due.push_back(predict_reading(word[ADC_W-1:0]));
    endtask

    // wait until every expected result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            bvm_pkg::REG_LOW_THRESHOLD: thresh_mv = val[THRESH_W-1:0];
            bvm_pkg::REG_PERSIST_LIMIT: persist   = val[PERSIST_W-1:0];
            bvm_pkg::REG_SCALE_Q16:     scale     = val;
            default: ;
        endcase
    endtask

    // sample on the requested side of the threshold, often right at the edge;
    // the pad bits above the sample are random now and then
    function automatic logic [S_TDATA_W-1:0] pick_sample(input bit want_low,
                                                         input int split);
        int  adc;
        logic [S_TDATA_W-1:0] word;
        if (want_low && split > 0)
            adc = ($urandom_range(3) == 0) ? split - 1 : $urandom_range(split - 1, 0);
        else if (!want_low && split < (1 << ADC_W))
            adc = ($urandom_range(3) == 0) ? split : $urandom_range(4095, split);
        else
            adc = $urandom_range(4095);
        word = S_TDATA_W'(adc);
        if ($urandom_range(3) == 0)
            word[S_TDATA_W-1:ADC_W] = (S_TDATA_W - ADC_W)'($urandom);
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_reading(input logic [M_TDATA_W-1:0] word);
        reading_t got;
        reading_t want;
        got = word[$bits(reading_t)-1:0];
        if (readings_due.size() == 0)
        begin
            report_mismatch($sformatf("result beat %h with nothing expected", word));
            return;
        end
        want = readings_due.pop_front();
        if (got.voltage_mv !== want.voltage_mv)
            report_mismatch($sformatf("voltage_mv %0d, expected %0d",
                                      got.voltage_mv, want.voltage_mv));
        if (got.average_counts !== want.average_counts)
            report_mismatch($sformatf("average_counts %0d, expected %0d",
                                      got.average_counts, want.average_counts));
        if (got.low_voltage !== want.low_voltage)
            report_mismatch($sformatf("low_voltage %b, expected %b",
                                      got.low_voltage, want.low_voltage));
    endtask

    // result side: random backpressure, every taken beat checked
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready) check_reading(m_axis_tdata);
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: too long without a beat on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset settings; the first beat fills the window, then field extremes
    task automatic test_first_fill();
        push_sample(16'h0FFF);
        push_sample(16'hFFFF);     // pad bits set, sample still 4095
        push_sample(16'h0000);
        push_sample(16'hF000);     // pad bits set, sample 0
        push_sample(16'h0800);
        push_sample(16'h0001);
        push_sample(16'h0FFE);
        push_sample(16'h0555);
        push_sample(16'h0AAA);
    endtask

    task automatic test_registers();
        drain();
        // unknown index is dropped; bits above 16 of a 16-bit register too
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(bvm_pkg::REG_LOW_THRESHOLD, 20'hA0D48);
        write_reg(bvm_pkg::REG_PERSIST_LIMIT, 20'hF0000);
        write_reg(bvm_pkg::REG_SCALE_Q16, 20'hFFFFF);
        push_sample(16'h0FFF);     // saturates voltage at the largest scale
        push_sample(16'h0000);
        push_sample(16'h0000);
        drain();
        // zero scale reads 0 mV; zero threshold never counts as low
        write_reg(bvm_pkg::REG_SCALE_Q16, '0);
        write_reg(bvm_pkg::REG_LOW_THRESHOLD, '0);
        push_sample(16'h0FFF);
        push_sample(16'h0123);
        drain();
        // largest threshold: everything but a clipped voltage is low
        write_reg(bvm_pkg::REG_LOW_THRESHOLD, 20'h0FFFF);
        write_reg(bvm_pkg::REG_SCALE_Q16, 20'hFFFFF);
        push_sample(16'h0FFF);
        push_sample(16'h0FFF);
        push_sample(16'h0010);
        push_sample(16'h0010);
    endtask

    // runs of low or high readings with random content, some raw noise
    task automatic run_phase(input int n_items);
        int split;
        int sent;
        int len;
        bit want_low;
        split = low_boundary();
        sent  = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                want_low = 1'($urandom_range(1));
                // runs up to long enough to fill the window and cross a small limit
                len = (persist < 64) ? $urandom_range(persist + 2 * WINDOW + 4, 1)
                                     : $urandom_range(40, 1);
                repeat (len) push_sample(pick_sample(want_low, split));
                sent += len;
            end
            else
            begin
                push_sample(S_TDATA_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_random_runs();
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD,
                              CFG_DATA_W'(bvm_pkg::THRESH_RESET));
                    write_reg(bvm_pkg::REG_SCALE_Q16, bvm_pkg::SCALE_RESET);
                    write_reg(bvm_pkg::REG_PERSIST_LIMIT,
                              CFG_DATA_W'($urandom_range(20)));
                end
                1:
                begin
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD, CFG_DATA_W'($urandom));
                    write_reg(bvm_pkg::REG_SCALE_Q16, 20'hFFFFF);
                    write_reg(bvm_pkg::REG_PERSIST_LIMIT, '0);
                end
                2:
                begin
                    no_gaps = 1'b1;
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD, CFG_DATA_W'($urandom));
                    write_reg(bvm_pkg::REG_SCALE_Q16, CFG_DATA_W'($urandom));
                    write_reg(bvm_pkg::REG_PERSIST_LIMIT,
                              CFG_DATA_W'($urandom_range(30)));
                end
                3:
                begin
                    no_gaps = 1'b0;
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD, '0);
                    write_reg(bvm_pkg::REG_SCALE_Q16, CFG_DATA_W'($urandom));
                end
                4:
                begin
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD, 20'h0FFFF);
                    write_reg(bvm_pkg::REG_SCALE_Q16,
                              CFG_DATA_W'($urandom_range(2 * bvm_pkg::SCALE_RESET, 1)));
                    write_reg(bvm_pkg::REG_PERSIST_LIMIT,
                              CFG_DATA_W'($urandom_range(15)));
                end
                default:
                begin
                    write_reg(bvm_pkg::REG_LOW_THRESHOLD,
                              CFG_DATA_W'($urandom_range(8000, 1000)));
                    write_reg(bvm_pkg::REG_SCALE_Q16,
                              CFG_DATA_W'($urandom_range(bvm_pkg::SCALE_RESET + 20000,
                                                         bvm_pkg::SCALE_RESET - 20000)));
                    write_reg(bvm_pkg::REG_PERSIST_LIMIT,
                              CFG_DATA_W'($urandom_range(40)));
                end
            endcase
            run_phase(PHASE_ITEMS);
        end
    endtask

    // zero scale with the top threshold: every reading is low
    task automatic test_persist_limits();
        drain();
        write_reg(bvm_pkg::REG_SCALE_Q16, '0);
        write_reg(bvm_pkg::REG_LOW_THRESHOLD, 20'h0FFFF);
        write_reg(bvm_pkg::REG_PERSIST_LIMIT, 20'd65534);
        repeat (LOW_ITEMS) push_sample(S_TDATA_W'($urandom));
        drain();
        // the largest limit can never be exceeded
        write_reg(bvm_pkg::REG_PERSIST_LIMIT, 20'h0FFFF);
        repeat (20) push_sample(S_TDATA_W'($urandom));
        drain();
        // limit below the running count: flag rises at once
        write_reg(bvm_pkg::REG_PERSIST_LIMIT, CFG_DATA_W'(LOW_ITEMS));
        repeat (5) push_sample(S_TDATA_W'($urandom));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_fill();
        test_registers();
        test_random_runs();
        test_persist_limits();

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (readings_due.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      readings_due.size()));
        if (err_cnt == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
